// ===== design/cdq_pkg.sv =====
// Package with the operation codes, status codes and field widths of the deque.
`default_nettype none

package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_O_W = 4;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== design/cdq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/circular_double_ended_queue.sv =====
// Top level of the circular double-ended queue of signed 32-bit words.
//
//  Channel   Direction  Handshake                    Ports
//  command   in         start high while busy low    i_operation, i_value
//  result    out        o_valid strobe, one cycle    o_status, o_popped_value,
//                                                    o_entry_count, o_is_empty,
//                                                    o_is_full, o_front_value,
//                                                    o_back_value
//
// Each transaction runs through every sequencer state before its result strobe;
// a new transaction can be accepted in the cycle the strobe is shown.
// The sequence is set by the single read port of the slot RAM: the popped word,
// the new front word and the new back word are read one after the other.
// Reset (synchronous, active low) empties the deque; the slot RAM is not cleared.
// The receiver cannot stall, so every result is shown for exactly one cycle.
`default_nettype none

module circular_double_ended_queue
    import cdq_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [OP_W-1:0]             i_operation,
    input  wire logic signed [DATA_W-1:0]    i_value,
    output logic                             o_valid,
    output logic [STATUS_W-1:0]              o_status,
    output logic signed [DATA_W-1:0]         o_popped_value,
    output logic [COUNT_O_W-1:0]             o_entry_count,
    output logic                             o_is_empty,
    output logic                             o_is_full,
    output logic signed [DATA_W-1:0]         o_front_value,
    output logic signed [DATA_W-1:0]         o_back_value
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // One-hot sequencer. The popped word is read first, then the state is
    // updated and the slot written, then the new front and back are read back.
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_POP_RD   = 6'b000010,
        S_UPDATE   = 6'b000100,
        S_FRONT_RD = 6'b001000,
        S_BACK_RD  = 6'b010000,
        S_REPORT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [OP_W-1:0]     r_op;
    logic [DATA_W-1:0]   r_value;
    logic [IDX_W-1:0]    r_front_idx, n_front_idx;
    logic [IDX_W-1:0]    r_back_idx, n_back_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_popped, n_popped;
    logic [DATA_W-1:0]   r_front_word;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_popped;
    logic [COUNT_O_W-1:0] r_out_count;
    logic                r_out_empty;
    logic                r_out_full;
    logic [DATA_W-1:0]   r_out_front;
    logic [DATA_W-1:0]   r_out_back;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    logic                op_is_push;
    logic                now_empty;

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_value),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign busy       = (r_state != S_IDLE);
    assign op_is_push = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_BACK);
    assign now_empty  = (r_count == '0);

    // Read address. The slot written in S_UPDATE is read no earlier than the
    // edge that ends S_FRONT_RD, so the write has always landed before the read;
    // the fixed order of the sequencer is the interlock.
    always_comb begin
        unique case (r_state)
            S_POP_RD:  ram_rd_addr = (r_op == OP_POP_FRONT) ? r_front_idx : r_back_idx;
            S_BACK_RD: ram_rd_addr = r_back_idx;
            default:   ram_rd_addr = r_front_idx;
        endcase
    end

    // State update, evaluated while the sequencer sits in S_UPDATE.
    always_comb begin
        n_front_idx = r_front_idx;
        n_back_idx  = r_back_idx;
        n_count     = r_count;
        n_status    = ST_DONE;
        n_popped    = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        if (op_is_push) begin
            if (r_count == FULL_CNT) begin
                n_status = ST_OVERFLOW;
            end else begin
                ram_wr_en = (r_state == S_UPDATE);
                n_count   = r_count + 1'b1;
                priority if (now_empty) begin
                    // The first word always lands in slot zero.
                    n_front_idx = '0;
                    n_back_idx  = '0;
                    ram_wr_addr = '0;
                end else if (r_op == OP_PUSH_FRONT) begin
                    n_front_idx = (r_front_idx == '0) ? LAST_IDX : r_front_idx - 1'b1;
                    ram_wr_addr = n_front_idx;
                end else begin
                    n_back_idx  = (r_back_idx == LAST_IDX) ? '0 : r_back_idx + 1'b1;
                    ram_wr_addr = n_back_idx;
                end
            end
        end else begin
            if (now_empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_popped = ram_rd_data;
                n_count  = r_count - 1'b1;
                priority if (r_count == CNT_W'(1)) begin
                    // Removing the last word returns both indices to slot zero.
                    n_front_idx = '0;
                    n_back_idx  = '0;
                end else if (r_op == OP_POP_FRONT) begin
                    n_front_idx = (r_front_idx == LAST_IDX) ? '0 : r_front_idx + 1'b1;
                end else begin
                    n_back_idx  = (r_back_idx == '0) ? LAST_IDX : r_back_idx - 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:     n_state = (start) ? S_POP_RD : S_IDLE;
            S_POP_RD:   n_state = S_UPDATE;
            S_UPDATE:   n_state = S_FRONT_RD;
            S_FRONT_RD: n_state = S_BACK_RD;
            S_BACK_RD:  n_state = S_REPORT;
            S_REPORT:   n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front_idx <= '0;
            r_back_idx  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_REPORT);
            if (r_state == S_UPDATE) begin
                r_front_idx <= n_front_idx;
                r_back_idx  <= n_back_idx;
                r_count     <= n_count;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_op    <= i_operation;
            r_value <= $unsigned(i_value);
        end
        if (r_state == S_UPDATE) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
        if (r_state == S_BACK_RD) begin
            r_front_word <= ram_rd_data;
        end
        if (r_state == S_REPORT) begin
            r_out_status <= r_status;
            r_out_popped <= r_popped;
            r_out_count  <= COUNT_O_W'(r_count);
            r_out_empty  <= now_empty;
            r_out_full   <= (r_count == FULL_CNT);
            r_out_front  <= now_empty ? '0 : r_front_word;
            r_out_back   <= now_empty ? '0 : ram_rd_data;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = $signed(r_out_popped);
    assign o_entry_count  = r_out_count;
    assign o_is_empty     = r_out_empty;
    assign o_is_full      = r_out_full;
    assign o_front_value  = $signed(r_out_front);
    assign o_back_value   = $signed(r_out_back);

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("deque count exceeds capacity");

    a_empty_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_front_idx == '0) && (r_back_idx == '0)))
        else $error("empty deque with nonzero indices");

    a_valid_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_REPORT))
        else $error("result strobe without a finished transaction");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OVERFLOW)) |-> o_is_full)
        else $error("overflow reported on a deque that is not full");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the circular double-ended queue.
`timescale 1ns / 1ps

module tb;
    import cdq_pkg::*;

    // The deque under test keeps its default capacity of eight slots.
    localparam int DEPTH       = 8;
    localparam int RANDOM_CMDS = 450;
    // Slowest correct run: every command waits the longest sender gap and a whole
    // transaction. The limit covers at most 500 commands many times over.
    localparam int CYCLE_LIMIT = 60000;

    // One command as the sender sees it. The gap is the number of idle cycles
    // before the command is offered.
    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        int unsigned              gap;
    } deque_cmd_t;

    // One result as the deque reports it.
    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] popped;
        logic [COUNT_O_W-1:0]     count;
        logic                     empty;
        logic                     full;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
    } deque_result_t;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic [OP_W-1:0]          i_operation = OP_PUSH_FRONT;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     busy;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_popped_value;
    logic [COUNT_O_W-1:0]     o_entry_count;
    logic                     o_is_empty;
    logic                     o_is_full;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_back_value;

    circular_double_ended_queue #(
        .CAPACITY(DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operation(i_operation),
        .i_value(i_value),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_popped_value(o_popped_value),
        .o_entry_count(o_entry_count),
        .o_is_empty(o_is_empty),
        .o_is_full(o_is_full),
        .o_front_value(o_front_value),
        .o_back_value(o_back_value)
    );

    always #5 i_clk = ~i_clk;

    // Commands waiting to be sent, and results predicted for accepted transactions.
    deque_cmd_t    cmd_queue[$];
    deque_result_t expected_results[$];

    // Shadow copy of the deque, updated once per accepted transaction.
    logic signed [DATA_W-1:0] shadow_slots[DEPTH];
    int shadow_front = 0;
    int shadow_back  = 0;
    int shadow_count = 0;

    int n_total      = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int n_overflow   = 0;
    int n_underflow  = 0;
    int n_full_seen  = 0;
    int n_empty_seen = 0;
    int cycle_count  = 0;
    int wait_cycles  = 0;

    deque_cmd_t    cmd;
    deque_result_t want;

    // Applies one operation to the shadow deque and returns what the block
    // must report for it. A refused push or pop leaves the shadow untouched,
    // and the value of a pop is never looked at.
    function automatic deque_result_t deque_apply(logic [OP_W-1:0] op,
                                                  logic signed [DATA_W-1:0] word);
        deque_result_t r;
        r.status = ST_DONE;
        r.popped = '0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_OVERFLOW;
            end else begin
                // The first word of an empty deque always lands in slot zero.
                if (shadow_count == 0) begin
                    shadow_front    = 0;
                    shadow_back     = 0;
                    shadow_slots[0] = word;
                end else if (op == OP_PUSH_FRONT) begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_front] = word;
                end else begin
                    shadow_back = (shadow_back + 1) % DEPTH;
                    shadow_slots[shadow_back] = word;
                end
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_UNDERFLOW;
            end else begin
                r.popped = (op == OP_POP_FRONT) ? shadow_slots[shadow_front]
                                                : shadow_slots[shadow_back];
                // Removing the last word sends both indexes back to slot zero.
                if (shadow_count == 1) begin
                    shadow_front = 0;
                    shadow_back  = 0;
                end else if (op == OP_POP_FRONT) begin
                    shadow_front = (shadow_front + 1) % DEPTH;
                end else begin
                    shadow_back = (shadow_back + DEPTH - 1) % DEPTH;
                end
                shadow_count--;
            end
        end
        r.count = COUNT_O_W'(shadow_count);
        r.empty = (shadow_count == 0);
        r.full  = (shadow_count == DEPTH);
        r.front = (shadow_count == 0) ? '0 : shadow_slots[shadow_front];
        r.back  = (shadow_count == 0) ? '0 : shadow_slots[shadow_back];
        return r;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want_v,
                                        logic [DATA_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected 0x%h, got 0x%h", name, want_v, got_v);
            n_errors++;
        end
    endfunction

    function automatic void add_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                                    int unsigned gap);
        deque_cmd_t c;
        c.op    = op;
        c.value = value;
        c.gap   = gap;
        cmd_queue.insert(cmd_queue.size(), c);
    endfunction

    // Mostly random words, with the extremes of the signed range mixed in.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Driver. A transaction is accepted at an edge where start is high and busy
    // is low; the values seen on the ports at that edge are what the deque took,
    // so the prediction is made from them right there. Start stays high while the
    // deque is busy, and it is only dropped when the next command still has gap
    // cycles to wait or nothing is left to send.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_operation  <= OP_PUSH_FRONT;
            i_value      <= '0;
            shadow_front = 0;
            shadow_back  = 0;
            shadow_count = 0;
            wait_cycles  = 0;
        end else begin
            if (start && !busy) begin
                expected_results.insert(expected_results.size(),
                                        deque_apply(i_operation, i_value));
                n_sent++;
            end
            if (!start || !busy) begin
                if (cmd_queue.size() != 0 && wait_cycles >= cmd_queue[0].gap) begin
                    cmd = cmd_queue[0];
                    cmd_queue.delete(0);
                    start       <= 1'b1;
                    i_operation <= cmd.op;
                    i_value     <= cmd.value;
                    wait_cycles = 0;
                end else begin
                    start <= 1'b0;
                    if (cmd_queue.size() != 0) begin
                        wait_cycles++;
                    end
                end
            end
        end
    end

    // Monitor. Each result is on the ports for a single cycle and is taken at the
    // edge that closes that cycle; it is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result with no transaction outstanding");
                n_errors++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                check_field("status", want.status, o_status);
                check_field("popped_value", want.popped, o_popped_value);
                check_field("entry_count", want.count, o_entry_count);
                check_field("is_empty", want.empty, o_is_empty);
                check_field("is_full", want.full, o_is_full);
                check_field("front_value", want.front, o_front_value);
                check_field("back_value", want.back, o_back_value);
                n_checked++;
                if (want.status == ST_OVERFLOW) n_overflow++;
                if (want.status == ST_UNDERFLOW) n_underflow++;
                if (want.full) n_full_seen++;
                if (want.empty) n_empty_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d of %0d transactions sent",
                   cycle_count, n_sent, n_total);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int seg_len;
        int push_pct;
        bit no_gaps;
        bit is_push;
        logic [OP_W-1:0] op;

        // Directed part. Pops on an empty deque, then a fill to capacity that
        // alternates ends (the first push-front from slot zero wraps the index),
        // pushes refused at full, a drain from both ends down to the last word,
        // and one more pop on the emptied deque. Pops carry junk values that
        // must be ignored.
        add_cmd(OP_POP_FRONT, 32'sh1234_5678, $urandom_range(0, 8));
        add_cmd(OP_POP_BACK, -32'sd1, $urandom_range(0, 8));
        add_cmd(OP_PUSH_FRONT, 32'sh7FFF_FFFF, $urandom_range(0, 8));
        add_cmd(OP_PUSH_BACK, 32'sh8000_0000, $urandom_range(0, 8));
        add_cmd(OP_PUSH_FRONT, 32'sh0000_0000, 0);
        add_cmd(OP_PUSH_BACK, -32'sd1, 0);
        add_cmd(OP_PUSH_FRONT, 32'sh5555_5555, $urandom_range(0, 8));
        add_cmd(OP_PUSH_BACK, 32'shAAAA_AAAA, 0);
        add_cmd(OP_PUSH_FRONT, 32'sh0000_0001, $urandom_range(0, 8));
        add_cmd(OP_PUSH_BACK, 32'shFFFF_FFFE, 0);
        add_cmd(OP_PUSH_FRONT, 32'sh0BAD_F00D, 0);
        add_cmd(OP_PUSH_BACK, 32'sh7654_3210, $urandom_range(0, 8));
        for (int k = 0; k < DEPTH / 2; k++) begin
            add_cmd(OP_POP_FRONT, -32'sd1, $urandom_range(0, 8));
            add_cmd(OP_POP_BACK, 32'sh7FFF_FFFF, $urandom_range(0, 8));
        end
        add_cmd(OP_POP_BACK, 32'sh8000_0000, 0);

        // Random part, in segments that lean toward pushes, pops or neither, so
        // the deque keeps swinging between full and empty. About one segment in
        // four is sent back to back with no idle cycles.
        while (cmd_queue.size() < 21 + RANDOM_CMDS) begin
            seg_len = $urandom_range(8, 30);
            case ($urandom_range(0, 2))
                0: push_pct = 25;
                1: push_pct = 50;
                default: push_pct = 75;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                is_push = ($urandom_range(0, 99) < push_pct);
                if (is_push) begin
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end else begin
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                end
                add_cmd(op, pick_value(), no_gaps ? 0 : $urandom_range(0, 8));
            end
        end
        n_total = cmd_queue.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transaction to be accepted and answered, then give the
        // deque more than the length of a whole transaction to show any stray result.
        while (n_sent != n_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            n_errors++;
        end

        $display("Covered %0d transactions: %0d refused pushes, %0d refused pops,",
                 n_checked, n_overflow, n_underflow);
        $display("%0d results with the deque full and %0d with it empty; %0d errors.",
                 n_full_seen, n_empty_seen, n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/cdq_pkg.sv
design/cdq_ram.sv
design/circular_double_ended_queue.sv
test/tb.sv
